// File: rtl/aes_pkg.sv
// ----------------------------------------------------------------------------
// AES package
// Shared types, S-box functions and round helpers for the AES block cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package aes_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_LOAD,
        ST_ROUND,
        ST_DONE
    } aes_state_t;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [0:0] OP_ENCRYPT = 1'b0;
    localparam logic [0:0] OP_DECRYPT = 1'b1;

    function automatic logic [7:0] sbox_fn(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[a];
    endfunction

    function automatic logic [7:0] inv_sbox_fn(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        return t[a];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox_fn(w[31:24]), sbox_fn(w[23:16]), sbox_fn(w[15:8]), sbox_fn(w[7:0])};
    endfunction

    // Byte i of the state (row i%4, column i/4) sits at bits 127-8i.
    function automatic logic [7:0] sb(input logic [127:0] s, input int i);
        return s[127-8*i -: 8];
    endfunction

    function automatic logic [127:0] enc_sub_shift(input logic [127:0] s);
        logic [127:0] t;
        t = '0;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[127-8*(r+4*c) -: 8] = sbox_fn(sb(s, r + 4*((c + r) % 4)));
        return t;
    endfunction

    function automatic logic [127:0] dec_shift_sub(input logic [127:0] s);
        logic [127:0] t;
        t = '0;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[127-8*(r+4*c) -: 8] = inv_sbox_fn(sb(s, r + 4*((c + 4 - r) % 4)));
        return t;
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] c);
        logic [7:0] a0, a1, a2, a3;
        a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
        return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
    endfunction

    // The inverse matrix is the forward one after a pre-multiplication
    // by {05 00 04 00}.
    function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
        logic [7:0] a0, a1, a2, a3, u, v;
        a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
        u = xtime(xtime(a0 ^ a2));
        v = xtime(xtime(a1 ^ a3));
        return mix_col({a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v});
    endfunction

    function automatic logic [127:0] mix_all(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        t = '0;
        for (int c = 0; c < 4; c++)
            t[127-32*c -: 32] = inv ? inv_mix_col(s[127-32*c -: 32])
                                    : mix_col(s[127-32*c -: 32]);
        return t;
    endfunction

endpackage

`default_nettype wire

// File: rtl/aes_block_cipher.sv
// ----------------------------------------------------------------------------
// AES block cipher
// ECB block cipher with a round-key memory expanded from the key registers.
// ----------------------------------------------------------------------------
//  Channel  Direction  Signals
//  cfg      in         cfg_valid/cfg_ready, cfg_index, cfg_data
//  in       in         in_valid/in_ready, operation, block_high, block_low,
//                      last_block
//  out      out        out_valid/out_ready, result_high, result_low,
//                      result_last
//
// A block starts with a load that reads the first round key, then runs
// one round per cycle, each fed by one read of the round-key memory.
// After reset or a key write, the first block first waits while the key
// schedule fills the memory, one word a cycle. The result is held in an
// output register; a stalled output holds the block in its done state and
// no new block is accepted until the transfer.
`default_nettype none

module aes_block_cipher #(
    parameter int KEY_WORDS = 4,
    parameter int ROUNDS    = 10
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [aes_pkg::CFG_INDEX_W:0] cfg_index,
    input  wire logic [63:0]                   cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          operation,
    input  wire logic [63:0]                   block_high,
    input  wire logic [63:0]                   block_low,
    input  wire logic                          last_block,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [63:0]                        result_high,
    output logic [63:0]                        result_low,
    output logic                               result_last
);
    import aes_pkg::*;

    localparam int RK_WORDS = 4 * (ROUNDS + 1);
    localparam int AW       = $clog2(RK_WORDS);
    localparam int RW       = $clog2(ROUNDS + 1);
    localparam int KIW      = $clog2(KEY_WORDS);

    aes_state_t state_reg, state_next;

    logic [63:0]      key_reg [4];
    logic             keys_ready_reg;
    // One row per round: the four schedule words of that round key.
    logic [127:0]     rk_mem [ROUNDS+1];
    logic [127:0]     rk_rd_reg;
    logic [31:0]      hist_reg [KEY_WORDS];   // last KEY_WORDS schedule words
    logic [AW:0]      ex_idx_reg;
    logic [7:0]       rcon_reg;
    logic [KIW-1:0]   ex_mod_reg;
    logic [127:0]     st_reg;
    logic             op_reg, last_reg;
    logic [RW-1:0]    round_reg;
    logic [127:0]     res_reg;
    logic             res_last_reg;

    logic             cfg_fire, in_fire, out_fire;
    logic [31:0]      ex_word;
    logic [RW-1:0]    rd_round;
    logic             rd_en;
    logic [127:0]     st_after;
    logic [127:0]     dec_pre;

    assign cfg_ready = (state_reg == ST_IDLE);
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid && out_ready;

    // Key schedule word for the current index.
    always_comb
    begin
        logic [31:0] t;
        logic [63:0] p;
        p = key_reg[ex_idx_reg[KIW-1:0] >> 1];
        t = hist_reg[KEY_WORDS-1];
        if (ex_mod_reg == '0)
            t = sub_word({t[23:0], t[31:24]}) ^ {rcon_reg, 24'h0};
        else if (KEY_WORDS > 6 && ex_mod_reg == KIW'(4))
            t = sub_word(t);
        if (ex_idx_reg < (AW+1)'(KEY_WORDS))
            ex_word = ex_idx_reg[0] ? p[31:0] : p[63:32];
        else
            ex_word = hist_reg[0] ^ t;
    end

    // Round-key read address: round number to fetch for the next cycle.
    always_comb
    begin
        rd_en    = 1'b0;
        rd_round = '0;
        if (state_reg == ST_LOAD)
        begin
            rd_en    = 1'b1;
            rd_round = op_reg ? RW'(ROUNDS) : '0;
        end
        else if (state_reg == ST_ROUND && round_reg != RW'(ROUNDS))
        begin
            rd_en    = 1'b1;
            rd_round = op_reg ? RW'(ROUNDS) - round_reg - RW'(1) : round_reg + RW'(1);
        end
    end

    // Round datapath. round_reg==0 is the initial key addition.
    always_comb
    begin
        dec_pre = dec_shift_sub(st_reg) ^ rk_rd_reg;
        if (round_reg == '0)
            st_after = st_reg ^ rk_rd_reg;
        else if (op_reg == OP_ENCRYPT)
            st_after = (round_reg == RW'(ROUNDS))
                       ? enc_sub_shift(st_reg) ^ rk_rd_reg
                       : mix_all(enc_sub_shift(st_reg), 1'b0) ^ rk_rd_reg;
        else
            st_after = (round_reg == RW'(ROUNDS)) ? dec_pre : mix_all(dec_pre, 1'b1);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_fire) state_next = keys_ready_reg ? ST_LOAD : ST_EXPAND;
            ST_EXPAND: if (ex_idx_reg == (AW+1)'(RK_WORDS - 1)) state_next = ST_LOAD;
            ST_LOAD:   state_next = ST_ROUND;
            ST_ROUND:  if (round_reg == RW'(ROUNDS)) state_next = ST_DONE;
            ST_DONE:   if (out_fire) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE) && !cfg_valid;
        out_valid = (state_reg == ST_DONE);
    end

    assign result_high = res_reg[127:64];
    assign result_low  = res_reg[63:0];
    assign result_last = res_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            keys_ready_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
                key_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_fire && cfg_index[CFG_INDEX_W] == 1'b0)
            begin
                key_reg[cfg_index[CFG_INDEX_W-1:0]] <= cfg_data;
                keys_ready_reg <= 1'b0;
            end
            else if (state_reg == ST_EXPAND && state_next == ST_LOAD)
                keys_ready_reg <= 1'b1;
        end
    end

    // Round-key memory: the schedule writes one word of a row per cycle, and
    // one registered read returns a whole round key. Reads never overlap the
    // schedule writes.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EXPAND)
            rk_mem[ex_idx_reg[AW-1:2]][127-32*int'(ex_idx_reg[1:0]) -: 32] <= ex_word;
        if (rd_en)
            rk_rd_reg <= rk_mem[rd_round];
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ex_idx_reg <= '0;
            ex_mod_reg <= '0;
            rcon_reg   <= 8'h01;
            st_reg     <= {block_high, block_low};
            op_reg     <= operation;
            last_reg   <= last_block;
        end
        else if (state_reg == ST_EXPAND)
        begin
            ex_idx_reg <= ex_idx_reg + (AW+1)'(1);
            ex_mod_reg <= (ex_mod_reg == KIW'(KEY_WORDS - 1)) ? '0 : ex_mod_reg + KIW'(1);
            if (ex_mod_reg == '0 && ex_idx_reg >= (AW+1)'(KEY_WORDS))
                rcon_reg <= xtime(rcon_reg);
            for (int i = 0; i < KEY_WORDS - 1; i++)
                hist_reg[i] <= hist_reg[i+1];
            hist_reg[KEY_WORDS-1] <= ex_word;
        end
        if (state_reg == ST_LOAD)
            round_reg <= '0;
        else if (state_reg == ST_ROUND)
        begin
            st_reg    <= st_after;
            round_reg <= round_reg + RW'(1);
            if (round_reg == RW'(ROUNDS))
            begin
                res_reg      <= st_after;
                res_last_reg <= last_reg;
            end
        end
    end

    a_cfg_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_fire |-> state_reg == ST_IDLE) else $error("config write while busy");
    a_no_double_accept: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_fire && cfg_fire)) else $error("input and config together");
    a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ROUND |-> round_reg <= RW'(ROUNDS)) else $error("round overrun");
    a_done_after_round: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == ST_ROUND) else $error("bad done entry");
    a_keys_before_load: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LOAD |-> keys_ready_reg) else $error("keys not ready");

endmodule

`default_nettype wire

// File: tb/aes_block_cipher_tb.sv
// ----------------------------------------------------------------------------
// AES block cipher testbench
// Sets keys through the register channel, then sends directed and random
// blocks for encryption and decryption. The directed table or an independent
// cipher model predicts each result, checked per field under varying flow control.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_block_cipher_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import aes_pkg::*;

    localparam logic [2:0] REG_KEY_PART_0 = 3'd0;
    localparam logic [2:0] REG_KEY_PART_1 = 3'd1;
    localparam logic [2:0] REG_KEY_PART_2 = 3'd2;
    localparam logic [2:0] REG_KEY_PART_3 = 3'd3;
    localparam logic [2:0] REG_UNUSED_LO  = 3'd4;
    localparam logic [2:0] REG_UNUSED_HI  = 3'd7;
    localparam int         RK_WORDS       = 44;
    localparam int         SETTLE_CYCLES  = 60;

    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
        logic        last;
    } cipher_block_t;

    typedef struct {
        bit          is_cfg;
        logic [2:0]  idx;
        logic [63:0] data;
        logic        op;
        logic [63:0] hi;
        logic [63:0] lo;
        logic        last;
        bit          typed;
        logic [63:0] exp_hi;
        logic [63:0] exp_lo;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        operation = OP_ENCRYPT;
    logic [63:0] block_high = '0;
    logic [63:0] block_low = '0;
    logic        last_block = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [63:0] result_high;
    logic [63:0] result_low;
    logic        result_last;

    aes_block_cipher u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .block_high  (block_high),
        .block_low   (block_low),
        .last_block  (last_block),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_high (result_high),
        .result_low  (result_low),
        .result_last (result_last)
    );

    always #4 clk = ~clk;

    logic [7:0] fwd_sbox [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    logic [7:0]  rev_sbox [256];

    // Mirror of the key registers and the expanded schedule.
    logic [63:0] key_regs [4];
    logic [31:0] round_keys [RK_WORDS];
    bit          schedule_valid;

    cipher_block_t pending_results [$];
    int            errors = 0;
    int            send_idle_pct = 0;
    int            stall_pct = 0;
    logic          hold_off = 1'b0;

    // Set by the sender alongside each payload; read when the block is taken.
    bit            cur_typed = 1'b0;
    logic [63:0]   cur_exp_hi = '0;
    logic [63:0]   cur_exp_lo = '0;

    function automatic logic [7:0] gf_double(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (a[i])
                acc ^= b;
            b = gf_double(b);
        end
        return acc;
    endfunction

    function automatic logic [31:0] subst_word(input logic [31:0] w);
        return {fwd_sbox[w[31:24]], fwd_sbox[w[23:16]], fwd_sbox[w[15:8]], fwd_sbox[w[7:0]]};
    endfunction

    function automatic void build_schedule();
        logic [7:0]  rcon;
        logic [31:0] t;
        rcon = 8'h01;
        for (int i = 0; i < RK_WORDS; i++)
        begin
            if (i < 4)
                round_keys[i] = i[0] ? key_regs[i >> 1][31:0] : key_regs[i >> 1][63:32];
            else
            begin
                t = round_keys[i - 1];
                if (i % 4 == 0)
                begin
                    t = subst_word({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
                    rcon = gf_double(rcon);
                end
                round_keys[i] = round_keys[i - 4] ^ t;
            end
        end
        schedule_valid = 1'b1;
    endfunction

    // State byte st[r + 4c] is row r, column c.
    function automatic logic [127:0] run_cipher(input logic op, input logic [127:0] blk);
        logic [7:0] st [16];
        logic [7:0] tmp [16];
        logic [7:0] col [4];
        logic [7:0] mat [4];
        logic [7:0] v;
        int         nr;
        logic [127:0] res;
        for (int i = 0; i < 16; i++)
            st[i] = blk[127 - 8*i -: 8];
        for (int step = 0; step <= 10; step++)
        begin
            nr = (op == OP_ENCRYPT) ? step : 10 - step;
            if (step > 0)
            begin
                // Substitution and row shift, forwards or backwards.
                for (int r = 0; r < 4; r++)
                    for (int c = 0; c < 4; c++)
                        if (op == OP_ENCRYPT)
                            tmp[r + 4*c] = fwd_sbox[st[r + 4*((c + r) % 4)]];
                        else
                            tmp[r + 4*c] = rev_sbox[st[r + 4*((c + 4 - r) % 4)]];
                st = tmp;
                if (op == OP_ENCRYPT && step < 10)
                begin
                    mat = '{8'h02, 8'h03, 8'h01, 8'h01};
                    for (int c = 0; c < 4; c++)
                    begin
                        for (int r = 0; r < 4; r++)
                            col[r] = st[r + 4*c];
                        for (int r = 0; r < 4; r++)
                        begin
                            v = '0;
                            for (int k = 0; k < 4; k++)
                                v ^= gf_mul(mat[k], col[(r + k) % 4]);
                            st[r + 4*c] = v;
                        end
                    end
                end
            end
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    st[r + 4*c] ^= round_keys[nr*4 + c][31 - 8*r -: 8];
            // The inverse cipher mixes after the key addition.
            if (op == OP_DECRYPT && step > 0 && step < 10)
            begin
                mat = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
                for (int c = 0; c < 4; c++)
                begin
                    for (int r = 0; r < 4; r++)
                        col[r] = st[r + 4*c];
                    for (int r = 0; r < 4; r++)
                    begin
                        v = '0;
                        for (int k = 0; k < 4; k++)
                            v ^= gf_mul(mat[k], col[(r + k) % 4]);
                        st[r + 4*c] = v;
                    end
                end
            end
        end
        for (int i = 0; i < 16; i++)
            res[127 - 8*i -: 8] = st[i];
        return res;
    endfunction

    initial
    begin
        for (int i = 0; i < 256; i++)
            rev_sbox[fwd_sbox[i]] = i[7:0];
        for (int i = 0; i < 4; i++)
            key_regs[i] = '0;
        schedule_valid = 1'b0;
    end

    // All handshakes are sampled at the falling edge, where every signal is
    // settled; a transfer seen here completes at the next rising edge.
    always @(negedge clk)
    begin
        cipher_block_t exp_blk;
        logic [127:0]  res;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready && cfg_index <= REG_KEY_PART_3)
            begin
                key_regs[cfg_index[1:0]] = cfg_data;
                schedule_valid = 1'b0;
            end
            if (in_valid && in_ready)
            begin
                if (!schedule_valid)
                    build_schedule();
                res = run_cipher(operation, {block_high, block_low});
                exp_blk.hi   = cur_typed ? cur_exp_hi : res[127:64];
                exp_blk.lo   = cur_typed ? cur_exp_lo : res[63:0];
                exp_blk.last = last_block;
                pending_results = {pending_results, exp_blk};
            end
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result transfer with nothing pending: %h %h",
                           result_high, result_low);
                    errors++;
                end
                else
                begin
                    exp_blk = pending_results.pop_front();
                    if (result_high !== exp_blk.hi)
                    begin
                        $error("result_high expected %h actual %h", exp_blk.hi, result_high);
                        errors++;
                    end
                    if (result_low !== exp_blk.lo)
                    begin
                        $error("result_low expected %h actual %h", exp_blk.lo, result_low);
                        errors++;
                    end
                    if (result_last !== exp_blk.last)
                    begin
                        $error("result_last expected %b actual %b", exp_blk.last, result_last);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || hold_off)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send_block(input logic op, input logic [63:0] hi, input logic [63:0] lo,
                              input logic last, input bit typed,
                              input logic [63:0] ehi, input logic [63:0] elo);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid   <= 1'b1;
        operation  <= op;
        block_high <= hi;
        block_low  <= lo;
        last_block <= last;
        cur_typed  <= typed;
        cur_exp_hi <= ehi;
        cur_exp_lo <= elo;
        do
            @(negedge clk);
        while (!in_ready);
        @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Leaves cfg_valid high after the transfer; the caller lowers it once the
    // last write of a sequence is done.
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(negedge clk);
        while (!cfg_ready);
        @(posedge clk);
    endtask

    task automatic send_random_block();
        logic [63:0] hi;
        logic [63:0] lo;
        int          pick;
        pick = $urandom_range(19);
        hi = {$urandom, $urandom};
        lo = {$urandom, $urandom};
        if (pick == 0)
        begin
            hi = '0;
            lo = '0;
        end
        else if (pick == 1)
        begin
            hi = '1;
            lo = '1;
        end
        send_block(1'($urandom_range(1)), hi, lo, 1'($urandom_range(1)), 1'b0, '0, '0);
    endtask

    stim_row_t directed [$] = '{
        // Before any key write the all-zero key is in force.
        '{0, 3'd0, 64'h0, OP_ENCRYPT, 64'h0, 64'h0, 1'b0,
          1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e},
        '{0, 3'd0, 64'h0, OP_DECRYPT, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e, 1'b1,
          1, 64'h0, 64'h0},
        '{0, 3'd0, 64'h0, OP_ENCRYPT, '1, '1, 1'b1, 0, 64'h0, 64'h0},
        '{0, 3'd0, 64'h0, OP_DECRYPT, '1, '1, 1'b0, 0, 64'h0, 64'h0},
        '{1, REG_KEY_PART_0, 64'h0001020304050607, OP_ENCRYPT, 64'h0, 64'h0, 1'b0, 0, 64'h0, 64'h0},
        '{1, REG_KEY_PART_1, 64'h08090a0b0c0d0e0f, OP_ENCRYPT, 64'h0, 64'h0, 1'b0, 0, 64'h0, 64'h0},
        '{1, REG_KEY_PART_2, '1, OP_ENCRYPT, 64'h0, 64'h0, 1'b0, 0, 64'h0, 64'h0},
        '{1, REG_KEY_PART_3, 64'ha5a5a5a5a5a5a5a5, OP_ENCRYPT, 64'h0, 64'h0, 1'b0, 0, 64'h0, 64'h0},
        '{0, 3'd0, 64'h0, OP_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0,
          1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a},
        '{0, 3'd0, 64'h0, OP_DECRYPT, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b1,
          1, 64'h0011223344556677, 64'h8899aabbccddeeff},
        // Writes above the last key register must leave the key alone.
        '{1, REG_UNUSED_LO, '1, OP_ENCRYPT, 64'h0, 64'h0, 1'b0, 0, 64'h0, 64'h0},
        '{1, REG_UNUSED_HI, '1, OP_ENCRYPT, 64'h0, 64'h0, 1'b0, 0, 64'h0, 64'h0},
        '{0, 3'd0, 64'h0, OP_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1,
          1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a},
        '{1, REG_KEY_PART_0, '1, OP_ENCRYPT, 64'h0, 64'h0, 1'b0, 0, 64'h0, 64'h0},
        '{1, REG_KEY_PART_1, '1, OP_ENCRYPT, 64'h0, 64'h0, 1'b0, 0, 64'h0, 64'h0},
        '{0, 3'd0, 64'h0, OP_ENCRYPT, 64'h0, 64'h0, 1'b0, 0, 64'h0, 64'h0},
        '{0, 3'd0, 64'h0, OP_DECRYPT, '1, '1, 1'b1, 0, 64'h0, 64'h0},
        '{0, 3'd0, 64'h0, OP_ENCRYPT, 64'h8000000000000000, 64'h0, 1'b0, 0, 64'h0, 64'h0},
        '{0, 3'd0, 64'h0, OP_DECRYPT, 64'h0, 64'h1, 1'b1, 0, 64'h0, 64'h0}
    };

    initial
    begin
        int idle_modes [4][2] = '{'{0, 0}, '{58, 0}, '{0, 58}, '{26, 26}};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            if (directed[i].is_cfg)
            begin
                wait_drained();
                write_reg(directed[i].idx, directed[i].data);
                cfg_valid <= 1'b0;
            end
            else
                send_block(directed[i].op, directed[i].hi, directed[i].lo, directed[i].last,
                           directed[i].typed, directed[i].exp_hi, directed[i].exp_lo);
        end

        for (int ph = 0; ph < 4; ph++)
        begin
            wait_drained();
            // Extreme keys in the first two phases, random ones after that.
            for (int k = 0; k < 4; k++)
                write_reg(k[2:0], ph == 0 ? 64'h0 : ph == 1 ? '1 : {$urandom, $urandom});
            write_reg(3'($urandom_range(REG_UNUSED_HI, REG_UNUSED_LO)), {$urandom, $urandom});
            cfg_valid <= 1'b0;
            send_idle_pct = idle_modes[ph][0];
            stall_pct     = idle_modes[ph][1];
            if (ph == 0)
            begin
                // A long output stall while blocks keep coming fills the core.
                fork
                    begin
                        hold_off <= 1'b1;
                        repeat (300) @(posedge clk);
                        hold_off <= 1'b0;
                    end
                join_none
            end
            for (int n = 0; n < 185; n++)
                send_random_block();
        end

        wait_drained();
        if (errors == 0)
            $display("** aes_block_cipher: PASSED **");
        else
            $display("** aes_block_cipher: FAILED **");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("** aes_block_cipher: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

// File: aes_block_cipher.f
rtl/aes_pkg.sv
rtl/aes_block_cipher.sv
tb/aes_block_cipher_tb.sv
